[hw/rtl/ecc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types, register indexes, palette codes and fixed-point constants of
// the escape-count colour mapper.
// ----------------------------------------------------------------------------
package ecc_pkg;

  // Default iteration count width
  localparam int unsigned COUNT_BITS_DEF = 20;
  // Largest number of byte chunks in count + 1 (count of up to 32 bits)
  localparam int unsigned NCH_MAX = 5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH  = 1'd1;

  // Palette codes
  localparam logic [2:0] PAL_RAINBOW  = 3'd0;
  localparam logic [2:0] PAL_GREY     = 3'd1;
  localparam logic [2:0] PAL_REDWHITE = 3'd2;
  localparam logic [2:0] PAL_FIRE     = 3'd3;
  localparam logic [2:0] PAL_VIBRANT  = 3'd4;
  localparam logic [2:0] PAL_REDHOT   = 3'd5;
  localparam logic [2:0] PAL_MATRIX   = 3'd6;

  // Chunk-sum width of the front reduction
  localparam int unsigned SUM_W = 17;

  // Queue depths
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 16;

  // Periods of n (whole units) per palette family
  localparam logic [6:0] K18 = 7'd18;
  localparam logic [6:0] K28 = 7'd28;
  localparam logic [6:0] K50 = 7'd50;
  localparam logic [6:0] K60 = 7'd60;
  localparam logic [6:0] K90 = 7'd90;

  // Reciprocals ceil(2^24 / K) for the chunk-sum remainder
  localparam logic [19:0] RK18 = 20'((64'd16777216 + 64'd17) / 64'd18);
  localparam logic [19:0] RK28 = 20'((64'd16777216 + 64'd27) / 64'd28);
  localparam logic [19:0] RK50 = 20'((64'd16777216 + 64'd49) / 64'd50);
  localparam logic [19:0] RK60 = 20'((64'd16777216 + 64'd59) / 64'd60);
  localparam logic [19:0] RK90 = 20'((64'd16777216 + 64'd89) / 64'd90);

  // Byte weights 256^i mod K, chunk 0 in the low slot
  localparam logic [NCH_MAX-1:0][6:0] WT18 = {7'(64'd4294967296 % 64'd18),
    7'(64'd16777216 % 64'd18), 7'(64'd65536 % 64'd18), 7'(64'd256 % 64'd18), 7'd1};
  localparam logic [NCH_MAX-1:0][6:0] WT28 = {7'(64'd4294967296 % 64'd28),
    7'(64'd16777216 % 64'd28), 7'(64'd65536 % 64'd28), 7'(64'd256 % 64'd28), 7'd1};
  localparam logic [NCH_MAX-1:0][6:0] WT50 = {7'(64'd4294967296 % 64'd50),
    7'(64'd16777216 % 64'd50), 7'(64'd65536 % 64'd50), 7'(64'd256 % 64'd50), 7'd1};
  localparam logic [NCH_MAX-1:0][6:0] WT60 = {7'(64'd4294967296 % 64'd60),
    7'(64'd16777216 % 64'd60), 7'(64'd65536 % 64'd60), 7'(64'd256 % 64'd60), 7'd1};
  localparam logic [NCH_MAX-1:0][6:0] WT90 = {7'(64'd4294967296 % 64'd90),
    7'(64'd16777216 % 64'd90), 7'(64'd65536 % 64'd90), 7'(64'd256 % 64'd90), 7'd1};

  // Reciprocals ceil(2^27 / D) for the wave divisions
  localparam logic [22:0] RD20 = 23'((64'd134217728 + 64'd19) / 64'd20);
  localparam logic [22:0] RD30 = 23'((64'd134217728 + 64'd29) / 64'd30);
  localparam logic [22:0] RD90 = 23'((64'd134217728 + 64'd89) / 64'd90);
  // Reciprocal ceil(2^20 / 15) for the HSV sector denominator
  localparam logic [16:0] R15  = 17'((64'd1048576 + 64'd14) / 64'd15);

  // Saturation / value / hue constants (12 and 8 fraction bits)
  localparam logic [12:0] ONE12     = 13'd4096;
  localparam logic [12:0] S_RAINBOW = 13'd2458;
  localparam logic [12:0] V_RAINBOW = 13'd3277;
  localparam logic [12:0] SV_FIRE   = 13'd3482;
  localparam logic [12:0] S_RW_MAX  = 13'd2867;
  localparam logic [16:0] H_MATRIX  = 17'd30720;
  localparam logic [18:0] RH_KNEE   = 19'd122880;
  localparam logic [16:0] SECT8     = 17'd15360;
  localparam logic [25:0] ONE_SECT  = 26'd62914560;

  // Item moved from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             esc;
  } ecc_item_t;

  // One result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } ecc_rgb_t;

  // Period constants chosen by the palette
  typedef struct packed {
    logic [6:0]               k;
    logic [19:0]              rk;
    logic [NCH_MAX-1:0][6:0] wt;
  } ecc_mod_t;

  function automatic ecc_mod_t mod_cfg(logic [2:0] pal);
    ecc_mod_t m;
    unique case (pal)
      PAL_GREY:               m = '{k: K60, rk: RK60, wt: WT60};
      PAL_REDWHITE:           m = '{k: K28, rk: RK28, wt: WT28};
      PAL_FIRE:               m = '{k: K50, rk: RK50, wt: WT50};
      PAL_REDHOT, PAL_MATRIX: m = '{k: K90, rk: RK90, wt: WT90};
      default:                m = '{k: K18, rk: RK18, wt: WT18};
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/ecc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_fifo
// Small register queue with a fill count; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module ecc_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       rd_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             wr_en, rd_en;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_en ? AW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = rd_en ? AW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (wr_en && !rd_en) begin
      count_d = CW'(count_q + 1'b1);
    end else if (rd_en && !wr_en) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/ecc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_front
// Forms count + 1 and folds it into a short weighted byte sum that keeps its
// residue modulo the selected palette's period.
// ----------------------------------------------------------------------------
module ecc_front #(
  parameter int unsigned COUNT_BITS = ecc_pkg::COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] iteration_count_i,
  input  logic                  escaped_i,
  input  logic [2:0]            palette_i,
  output ecc_pkg::ecc_item_t    item_o
);

  localparam int unsigned NCH = (COUNT_BITS + 8) / 8;

  ecc_pkg::ecc_mod_t         mc;
  logic [NCH*8-1:0]          xpad;
  logic [ecc_pkg::SUM_W-1:0] sum;

  assign mc   = ecc_pkg::mod_cfg(palette_i);
  assign xpad = (NCH*8)'(iteration_count_i) + (NCH*8)'(1);

  // Weight each byte by 256^i mod K and add
  always_comb begin
    sum = '0;
    for (int i = 0; i < NCH; i++) begin
      sum = ecc_pkg::SUM_W'(sum + ecc_pkg::SUM_W'(xpad[i*8 +: 8] * mc.wt[i]));
    end
  end

  assign item_o.sum = sum;
  assign item_o.esc = escaped_i;

endmodule

[hw/rtl/ecc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_back
// Seven-stage pipeline: remainder of n, wave shaping, wave division, palette
// selection, HSV sector split and the channel products.
// ----------------------------------------------------------------------------
module ecc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ecc_pkg::ecc_item_t    in_item_i,
  input  logic [2:0]            palette_i,
  input  logic signed [12:0]    smooth_i,
  output logic                  out_valid_o,
  output ecc_pkg::ecc_rgb_t     out_rgb_o
);

  logic [7:1] v_q;
  ecc_pkg::ecc_mod_t mc;
  assign mc = ecc_pkg::mod_cfg(palette_i);

  // Stage 1: quotient of the chunk sum by K
  logic [36:0] prod1;
  logic [16:0] sum1_q;
  logic [12:0] q1_q;
  logic        esc1_q;
  assign prod1 = 37'(in_item_i.sum) * 37'(mc.rk);

  always_ff @(posedge clk_i) begin
    sum1_q <= in_item_i.sum;
    q1_q   <= prod1[36:24];
    esc1_q <= in_item_i.esc;
  end

  // Stage 2: remainder, scale and subtract the smoothing offset, wrap once
  logic [19:0]        qk;
  logic [16:0]        rem;
  logic signed [20:0] sv;
  logic [20:0]        mk, nm_w;
  logic [18:0]        nm_q;
  logic               esc2_q;
  assign qk  = 20'(q1_q * mc.k);
  assign rem = 17'(sum1_q - qk[16:0]);
  assign sv  = $signed({2'b00, rem[6:0], 12'h000}) - $signed({{8{smooth_i[12]}}, smooth_i});
  assign mk  = {2'b00, mc.k, 12'h000};

  always_comb begin
    if (sv[20]) begin
      nm_w = 21'(sv + $signed(mk));
    end else if (21'(sv) >= mk) begin
      nm_w = 21'(sv - $signed(mk));
    end else begin
      nm_w = 21'(sv);
    end
  end

  always_ff @(posedge clk_i) begin
    nm_q   <= nm_w[18:0];
    esc2_q <= esc1_q;
  end

  // Stage 3: triangle waves, grey level and rainbow hue
  logic [19:0] tm, tc, td;
  logic [21:0] gm, gd, gt;
  logic [7:0]  glvl;
  logic [22:0] rh_w;
  logic [18:0] tri_q, tri4_q;
  logic [7:0]  glvl_q, glvl4_q;
  logic [16:0] rh_q, rh4_q;
  logic        esc3_q, esc4_q;

  always_comb begin
    unique case (palette_i)
      ecc_pkg::PAL_REDWHITE: begin
        tm = {1'b0, nm_q};
        tc = 20'd57344;
      end
      ecc_pkg::PAL_FIRE: begin
        tm = {nm_q, 1'b0};
        tc = 20'd204800;
      end
      default: begin
        tm = {nm_q, 1'b0};
        tc = 20'd368640;
      end
    endcase
    td   = (tm >= tc) ? 20'(tm - tc) : 20'(tc - tm);
    gm   = 22'({nm_q, 4'h0}) + 22'(nm_q);
    gd   = (gm >= 22'd2088960) ? 22'(gm - 22'd2088960) : 22'(22'd2088960 - gm);
    gt   = 22'(22'd2088960 - gd);
    glvl = (gt[20:13] < 8'd30) ? 8'd30 : gt[20:13];
    rh_w = 23'({nm_q, 4'h0}) + 23'({nm_q, 2'b00});
  end

  always_ff @(posedge clk_i) begin
    tri_q  <= 19'(tc - td);
    glvl_q <= glvl;
    rh_q   <= rh_w[20:4];
    esc3_q <= esc2_q;
  end

  // Stage 4: divide the wave by a constant through its reciprocal
  logic [22:0] rd;
  logic [41:0] prod4;
  logic [13:0] quo_q;
  always_comb begin
    unique case (palette_i)
      ecc_pkg::PAL_REDWHITE: rd = ecc_pkg::RD20;
      ecc_pkg::PAL_MATRIX:   rd = ecc_pkg::RD90;
      default:               rd = ecc_pkg::RD30;
    endcase
  end
  assign prod4 = 42'(tri_q) * 42'(rd);

  always_ff @(posedge clk_i) begin
    quo_q   <= prod4[40:27];
    tri4_q  <= tri_q;
    glvl4_q <= glvl_q;
    rh4_q   <= rh_q;
    esc4_q  <= esc3_q;
  end

  // Stage 5: pick hue, saturation and value for the palette
  logic [16:0] h5;
  logic [12:0] s5, v5;
  logic [16:0] h_q;
  logic [12:0] s_q, v_q5;
  logic        g_q;
  logic [7:0]  lvl_q;

  always_comb begin
    h5 = '0;
    s5 = ecc_pkg::ONE12;
    v5 = '0;
    unique case (palette_i)
      ecc_pkg::PAL_GREY: begin
        v5 = '0;
      end
      ecc_pkg::PAL_REDWHITE: begin
        v5 = ecc_pkg::ONE12;
        if (esc4_q) begin
          s5 = (quo_q > 14'(ecc_pkg::S_RW_MAX)) ? ecc_pkg::S_RW_MAX : quo_q[12:0];
        end
      end
      ecc_pkg::PAL_FIRE: begin
        s5 = ecc_pkg::SV_FIRE;
        if (esc4_q) begin
          h5 = 17'(tri4_q[18:4]);
          v5 = ecc_pkg::SV_FIRE;
        end
      end
      ecc_pkg::PAL_REDHOT: begin
        if (esc4_q) begin
          if (tri4_q <= ecc_pkg::RH_KNEE) begin
            v5 = quo_q[12:0];
          end else begin
            h5 = 17'(19'(tri4_q - ecc_pkg::RH_KNEE) >> 4);
            v5 = ecc_pkg::ONE12;
          end
        end
      end
      ecc_pkg::PAL_MATRIX: begin
        h5 = ecc_pkg::H_MATRIX;
        if (esc4_q) begin
          v5 = quo_q[12:0];
        end
      end
      ecc_pkg::PAL_VIBRANT: begin
        if (esc4_q) begin
          h5 = rh4_q;
          v5 = ecc_pkg::ONE12;
        end
      end
      default: begin
        s5 = ecc_pkg::S_RAINBOW;
        if (esc4_q) begin
          h5 = rh4_q;
          v5 = ecc_pkg::V_RAINBOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h5;
    s_q   <= s5;
    v_q5  <= v5;
    g_q   <= (palette_i == ecc_pkg::PAL_GREY);
    lvl_q <= esc4_q ? glvl4_q : 8'd0;
  end

  // Stage 6: sector, fraction, 255v and s*f
  logic [2:0]  sec6;
  logic [16:0] base6;
  logic [16:0] fr_w;
  logic [20:0] a_w;
  logic [26:0] sfr_w;
  logic [2:0]  sec_q;
  logic [19:0] a_q;
  logic [25:0] sfr_q;
  logic [12:0] s6_q;
  logic        g6_q;
  logic [7:0]  lvl6_q;

  always_comb begin
    priority if (h_q >= 17'd76800) begin
      sec6 = 3'd5;
    end else if (h_q >= 17'd61440) begin
      sec6 = 3'd4;
    end else if (h_q >= 17'd46080) begin
      sec6 = 3'd3;
    end else if (h_q >= 17'd30720) begin
      sec6 = 3'd2;
    end else if (h_q >= ecc_pkg::SECT8) begin
      sec6 = 3'd1;
    end else begin
      sec6 = 3'd0;
    end
    base6 = 17'(sec6 * ecc_pkg::SECT8);
    fr_w  = 17'(h_q - base6);
    a_w   = 21'({v_q5, 8'h00}) - 21'(v_q5);
    sfr_w = 27'(s_q * fr_w[13:0]);
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec6;
    a_q    <= a_w[19:0];
    sfr_q  <= sfr_w[25:0];
    s6_q   <= s_q;
    g6_q   <= g_q;
    lvl6_q <= lvl_q;
  end

  // Stage 7: channel products Q, T, P and V
  logic [25:0] bq;
  logic [26:0] s15;
  logic [27:0] bt_w;
  logic [45:0] pq, pt;
  logic [32:0] pp;
  logic [11:0] yq_q, yt_q;
  logic [7:0]  vp_q, vv_q;
  logic [2:0]  sec7_q;
  logic        g7_q;
  logic [7:0]  lvl7_q;

  assign bq   = 26'(ecc_pkg::ONE_SECT - sfr_q);
  assign s15  = 27'({s6_q, 14'h0000}) - 27'({s6_q, 10'h000});
  assign bt_w = 28'(ecc_pkg::ONE_SECT) - 28'(s15) + 28'(sfr_q);
  assign pq   = 46'(a_q) * 46'(bq);
  assign pt   = 46'(a_q) * 46'(bt_w[25:0]);
  assign pp   = 33'(a_q) * 33'(13'(ecc_pkg::ONE12 - s6_q));

  always_ff @(posedge clk_i) begin
    yq_q   <= pq[45:34];
    yt_q   <= pt[45:34];
    vp_q   <= pp[31:24];
    vv_q   <= a_q[19:12];
    sec7_q <= sec_q;
    g7_q   <= g6_q;
    lvl7_q <= lvl6_q;
  end

  // Output: divide by 15 and route the channels by sector
  logic [28:0] dq, dt;
  logic [7:0]  vq, vt;
  assign dq = 29'(yq_q) * 29'(ecc_pkg::R15);
  assign dt = 29'(yt_q) * 29'(ecc_pkg::R15);
  assign vq = dq[27:20];
  assign vt = dt[27:20];

  always_comb begin
    if (g7_q) begin
      out_rgb_o = '{red: lvl7_q, green: 8'd0, blue: 8'd0};
    end else begin
      unique case (sec7_q)
        3'd0:    out_rgb_o = '{red: vv_q, green: vt,   blue: vp_q};
        3'd1:    out_rgb_o = '{red: vq,   green: vv_q, blue: vp_q};
        3'd2:    out_rgb_o = '{red: vp_q, green: vv_q, blue: vt};
        3'd3:    out_rgb_o = '{red: vp_q, green: vq,   blue: vv_q};
        3'd4:    out_rgb_o = '{red: vt,   green: vp_q, blue: vv_q};
        default: out_rgb_o = '{red: vv_q, green: vp_q, blue: vq};
      endcase
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:1], in_valid_i};
    end
  end

  assign out_valid_o = v_q[7];

endmodule

[hw/rtl/escape_count_colour_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_count_colour_mapper
// Maps an escape-time pixel count to an 8-bit RGB colour through one of
// seven smoothed palettes.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one colour per clock for as long as
// the result side keeps popping. A pixel passes the front reduction into a
// two-entry queue, then through the seven register stages of the back
// pipeline into a sixteen-entry result queue. The back issues a pixel only
// while the result queue has a free slot reserved for it, so the pipeline
// never stalls. Write palette_select and smooth_factor only while no pixel
// is in flight.
module escape_count_colour_mapper #(
  parameter int unsigned COUNT_BITS = ecc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ecc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [COUNT_BITS-1:0]          iteration_count_i,
  input  logic                           escaped_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o
);

  localparam int unsigned MID_CW = $clog2(ecc_pkg::MID_DEPTH + 1);
  localparam int unsigned OUT_CW = $clog2(ecc_pkg::OUT_DEPTH + 1);
  localparam int unsigned ITEM_W = $bits(ecc_pkg::ecc_item_t);
  localparam int unsigned RGB_W  = $bits(ecc_pkg::ecc_rgb_t);

  logic [2:0]         palette_q;
  logic signed [12:0] smooth_q;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= ecc_pkg::PAL_RAINBOW;
      smooth_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ecc_pkg::CFG_PALETTE) begin
        palette_q <= cfg_data_i[2:0];
      end else if (cfg_idx_i == ecc_pkg::CFG_SMOOTH) begin
        smooth_q <= $signed(cfg_data_i);
      end
    end
  end

  // Front: reduce the count
  ecc_pkg::ecc_item_t front_item, mid_item;
  logic               mid_empty, issue;
  logic [MID_CW-1:0]  mid_count;

  ecc_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .iteration_count_i (iteration_count_i),
    .escaped_i         (escaped_i),
    .palette_i         (palette_q),
    .item_o            (front_item)
  );

  ecc_fifo #(.DEPTH(ecc_pkg::MID_DEPTH), .WIDTH(ITEM_W)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .full_o  (full),
    .rd_i    (issue),
    .rdata_o (mid_item),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // Reserve a result slot for every request issued to the back
  logic [OUT_CW-1:0] reserved_q, reserved_d;
  logic              out_pop;
  assign issue   = !mid_empty && (reserved_q < OUT_CW'(ecc_pkg::OUT_DEPTH));
  assign out_pop = pop && !empty;

  always_comb begin
    reserved_d = reserved_q;
    if (issue && !out_pop) begin
      reserved_d = OUT_CW'(reserved_q + 1'b1);
    end else if (out_pop && !issue) begin
      reserved_d = OUT_CW'(reserved_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
    end else begin
      reserved_q <= reserved_d;
    end
  end

  // Back: colour pipeline
  logic              back_valid, out_full;
  ecc_pkg::ecc_rgb_t back_rgb, out_rgb;
  logic [OUT_CW-1:0] out_count;

  ecc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (issue),
    .in_item_i   (mid_item),
    .palette_i   (palette_q),
    .smooth_i    (smooth_q),
    .out_valid_o (back_valid),
    .out_rgb_o   (back_rgb)
  );

  ecc_fifo #(.DEPTH(ecc_pkg::OUT_DEPTH), .WIDTH(RGB_W)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (back_valid),
    .wdata_i (back_rgb),
    .full_o  (out_full),
    .rd_i    (pop),
    .rdata_o (out_rgb),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign red_o   = out_rgb.red;
  assign green_o = out_rgb.green;
  assign blue_o  = out_rgb.blue;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reserved_q >= out_count)
    else $error("result reservations below result queue fill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_valid |-> !out_full)
    else $error("back pipeline wrote into a full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> ##7 back_valid)
    else $error("issued request did not leave the back pipeline on time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> mid_count != '0)
    else $error("issue from an empty middle queue");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape-count colour mapper.
// ----------------------------------------------------------------------------
// Walks a short table of directed pixels, then several phases of random
// pixels, each phase under its own palette and smoothing offset. Every
// request's typed or bit-accurately predicted colour is held in a
// queue; each colour popped is compared channel by channel with the oldest
// entry. Both sides wait a random number of cycles before each request.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CNT_W     = ecc_pkg::COUNT_BITS_DEF;
  localparam int unsigned WDOG_MAX  = 2000;
  localparam int unsigned DRAIN_CYC = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  typedef struct {
    logic [2:0]       pal;
    logic [12:0]      smooth;
    logic [CNT_W-1:0] cnt;
    logic             esc;
    bit               typed;
    colour_t          want;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [ecc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [ecc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           push = 1'b0;
  logic                           full;
  logic [CNT_W-1:0]               iteration_count_i = '0;
  logic                           escaped_i = 1'b0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [7:0]                     red_o, green_o, blue_o;

  colour_t          colour_q[$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  logic [2:0]       cur_pal = ecc_pkg::PAL_RAINBOW;
  logic [12:0]      cur_smooth = '0;

  escape_count_colour_mapper #(.COUNT_BITS(CNT_W)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .iteration_count_i, .escaped_i,
    .empty, .pop, .red_o, .green_o, .blue_o
  );

  always #1 clk_i = ~clk_i;

  // HSV to RGB with truncating divisions
  function automatic colour_t hsv_to_rgb(longint unsigned h8, longint unsigned s12,
                                         longint unsigned v12);
    longint unsigned sect, fr, vv, vp, vq, vt;
    colour_t c;
    if (s12 > 4096) s12 = 4096;
    if (v12 > 4096) v12 = 4096;
    if (v12 == 0) return '0;
    sect = (h8 / 15360) % 6;
    fr   = h8 % 15360;
    vv = v12 * 255 / 4096;
    vp = v12 * 255 * (4096 - s12) / (4096 * 4096);
    vq = v12 * 255 * (64'd4096 * 15360 - s12 * fr) / (64'd4096 * 4096 * 15360);
    vt = v12 * 255 * (64'd4096 * 15360 - s12 * (15360 - fr)) / (64'd4096 * 4096 * 15360);
    case (sect)
      0: c = '{vv[7:0], vt[7:0], vp[7:0]};
      1: c = '{vq[7:0], vv[7:0], vp[7:0]};
      2: c = '{vp[7:0], vv[7:0], vt[7:0]};
      3: c = '{vp[7:0], vq[7:0], vv[7:0]};
      4: c = '{vt[7:0], vp[7:0], vv[7:0]};
      default: c = '{vv[7:0], vp[7:0], vq[7:0]};
    endcase
    return c;
  endfunction

  // Triangle of 2n with the given half period, 12 fraction bits
  function automatic longint unsigned tri2n(longint unsigned n12, longint unsigned half);
    longint unsigned m, c, d;
    m = (2 * n12) % ((2 * half) << 12);
    c = half << 12;
    d = (m >= c) ? m - c : c - m;
    return c - d;
  endfunction

  function automatic colour_t map_colour(logic [CNT_W-1:0] cnt, logic esc);
    longint unsigned n12, h8, s12, v12, t, m, d, c;
    colour_t rgb;
    n12 = longint'((longint'(cnt) + 1) << 12) - longint'($signed(cur_smooth));
    h8 = 0; s12 = 4096; v12 = 0;
    case (cur_pal)
      ecc_pkg::PAL_GREY: begin
        rgb = '0;
        if (esc) begin
          c = 255 << 13;
          m = (n12 * 17) % (1020 << 12);
          d = (m >= c) ? m - c : c - m;
          t = (c - d) >> 13;
          if (t < 30) t = 30;
          rgb.red = t[7:0];
        end
        return rgb;
      end
      ecc_pkg::PAL_REDWHITE: begin
        v12 = 4096;
        if (esc) begin
          c = 14 << 12;
          m = n12 % (28 << 12);
          d = (m >= c) ? m - c : c - m;
          s12 = (c - d) / 20;
          if (s12 > 2867) s12 = 2867;
        end
      end
      ecc_pkg::PAL_FIRE: begin
        s12 = 3482;
        if (esc) begin
          h8 = tri2n(n12, 50) >> 4;
          v12 = 3482;
        end
      end
      ecc_pkg::PAL_REDHOT: begin
        if (esc) begin
          t = tri2n(n12, 90);
          if (t <= (30 << 12)) v12 = t / 30;
          else begin
            h8 = (t - (30 << 12)) >> 4;
            v12 = 4096;
          end
        end
      end
      ecc_pkg::PAL_MATRIX: begin
        h8 = 120 << 8;
        if (esc) v12 = tri2n(n12, 90) / 90;
      end
      ecc_pkg::PAL_VIBRANT: begin
        if (esc) begin
          h8 = ((20 * n12) % (360 << 12)) >> 4;
          v12 = 4096;
        end
      end
      default: begin
        s12 = 2458;
        if (esc) begin
          h8 = ((20 * n12) % (360 << 12)) >> 4;
          v12 = 3277;
        end
      end
    endcase
    return hsv_to_rgb(h8, s12, v12);
  endfunction

  task automatic report(string what, colour_t got, colour_t want);
    $display("%0t mismatch %s: got %h/%h/%h want %h/%h/%h", $time, what,
             got.red, got.green, got.blue, want.red, want.green, want.blue);
    mismatches++;
  endtask

  // Drive one register write; the caller drops the write enable afterwards
  task automatic write_reg(logic [ecc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ecc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == ecc_pkg::CFG_PALETTE) cur_pal = val[2:0];
    else cur_smooth = val;
  endtask

  // Wait for every colour, then let the pipeline settle
  task automatic drain();
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [2:0] pal, logic [12:0] sm);
    if (pal != cur_pal || sm != cur_smooth) begin
      push <= 1'b0;
      drain();
      write_reg(ecc_pkg::CFG_PALETTE, ecc_pkg::CFG_DATA_W'(pal));
      write_reg(ecc_pkg::CFG_SMOOTH, sm);
      cfg_we_i <= 1'b0;
    end
  endtask

  // Push one pixel after a random gap; a typed expectation replaces the predictor
  task automatic send(logic [CNT_W-1:0] cnt, logic esc, bit typed, colour_t want);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    iteration_count_i <= cnt;
    escaped_i <= esc;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    colour_q.push_back(typed ? want : map_colour(cnt, esc));
  endtask

  // Pop side: random stall before each request, check against the oldest entry
  initial begin : result_side
    int stall;
    colour_t got, want;
    wait (rst_ni);
    forever begin
      stall = $urandom_range(0, 5);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got = '{red_o, green_o, blue_o};
      if (colour_q.size() == 0) report("unexpected colour", got, '0);
      else begin
        want = colour_q.pop_front();
        if (got.red != want.red) report("red", got, want);
        if (got.green != want.green) report("green", got, want);
        if (got.blue != want.blue) report("blue", got, want);
      end
    end
  end

  // Watchdog: count cycles with no request accepted on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    logic [2:0] pal;
    logic [12:0] sm;
    int ph, k;
    logic [CNT_W-1:0] cnt;
    // Directed table: inside-set blacks, red-white inside, extremes, palette 7
    rows = '{
      '{ecc_pkg::PAL_RAINBOW,  13'h0000, '0, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_RAINBOW,  13'h0000, '1, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_GREY,     13'h0000, 20'd5, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_GREY,     13'h0000, '0, 1'b1, 1'b1, '{8'd30, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_GREY,     13'h0000, '1, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_REDWHITE, 13'h0000, 20'd9, 1'b0, 1'b1, '{8'd255, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_REDWHITE, 13'h0000, 20'd13, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_FIRE,     13'h0000, 20'd3, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_FIRE,     13'h0000, 20'd24, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_VIBRANT,  13'h0000, 20'd1, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_VIBRANT,  13'h0000, 20'd8, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_REDHOT,   13'h0000, 20'd7, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_REDHOT,   13'h0000, 20'd14, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_REDHOT,   13'h0000, 20'd40, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_MATRIX,   13'h0000, 20'd2, 1'b0, 1'b1, '{8'd0, 8'd0, 8'd0}},
      '{ecc_pkg::PAL_MATRIX,   13'h0000, 20'd44, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_MATRIX,   13'h0fff, '0, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_RAINBOW,  13'h0fff, '0, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_RAINBOW,  13'h1000, '1, 1'b1, 1'b0, '0},
      '{ecc_pkg::PAL_GREY,     13'h1000, 20'd29, 1'b1, 1'b0, '0},
      '{3'd7,                  13'h1000, 20'd17, 1'b1, 1'b0, '0},
      '{3'd7,                  13'h0800, 20'haaaaa, 1'b1, 1'b0, '0},
      '{3'd7,                  13'h0800, 20'h55555, 1'b0, 1'b0, '0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      set_mode(rows[i].pal, rows[i].smooth);
      send(rows[i].cnt, rows[i].esc, rows[i].typed, rows[i].want);
    end
    // Random phases: every palette, offsets including both extremes
    for (ph = 0; ph < 20; ph++) begin
      pal = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      case (ph % 4)
        0: sm = 13'h1000;
        1: sm = 13'h0fff;
        2: sm = 13'h0000;
        default: sm = 13'($urandom);
      endcase
      set_mode(pal, sm);
      for (k = 0; k < 100; k++) begin
        cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 400));
        send(cnt, ($urandom_range(0, 4) != 0), 1'b0, '0);
      end
    end
    push <= 1'b0;
    drain();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
